FILE: rtl/ppz_pkg.sv
// Package for the polynomial predictor / zigzag residual block.
// Holds the sample width, the input and result word types and the fold helpers.
// No dependencies.
`timescale 1ns / 1ps

package ppz_pkg;

  // Width of every sample, code and residual; the stereo sum is one bit wider
  localparam int SAMPLE_W = 16;

  // Warm-up counter saturates at the full predictor order
  localparam int ORDER     = 3;
  localparam int COUNT_W   = 2;

  // Mode register codes
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  // One input word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic signed [SAMPLE_W-1:0] folded_code;
    logic                       start_of_stream;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] folded_residual;
  } out_word_t;

  // Zigzag fold: r >= 0 gives 2r, r < 0 gives -2r-1, which is ~(2r)
  function automatic logic [SAMPLE_W-1:0] fold(input logic [SAMPLE_W-1:0] r);
    logic [SAMPLE_W-1:0] dbl;
    dbl  = {r[SAMPLE_W-2:0], 1'b0};
    fold = dbl ^ {SAMPLE_W{r[SAMPLE_W-1]}};
  endfunction

  // Zigzag unfold, n read as signed: even n gives n/2, odd n gives -(n+1)/2
  function automatic logic [SAMPLE_W-1:0] unfold(input logic [SAMPLE_W-1:0] n);
    logic [SAMPLE_W-1:0] half;
    half   = {n[SAMPLE_W-1], n[SAMPLE_W-1:1]};
    unfold = half ^ {SAMPLE_W{n[0]}};
  endfunction

endpackage

FILE: rtl/ppz_predictor.sv
// Sample history and warm-up counter with the fixed polynomial prediction.
// Uses ppz_pkg for widths; fed the new sample by the top level on each advance.
`timescale 1ns / 1ps

module ppz_predictor (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             start,
  input  logic [ppz_pkg::SAMPLE_W-1:0]     new_sample,
  output logic [ppz_pkg::SAMPLE_W-1:0]     prediction
);

  logic [ppz_pkg::SAMPLE_W-1:0] prev1;
  logic [ppz_pkg::SAMPLE_W-1:0] prev2;
  logic [ppz_pkg::SAMPLE_W-1:0] prev3;
  logic [ppz_pkg::COUNT_W-1:0]  warmup;
  logic [ppz_pkg::COUNT_W-1:0]  count;
  logic [ppz_pkg::COUNT_W-1:0]  warmup_next;
  logic [ppz_pkg::SAMPLE_W-1:0] diff;
  logic [ppz_pkg::SAMPLE_W-1:0] slope;

  // Start flag restarts warm-up for this word
  assign count = start ? '0 : warmup;

  // Saturate the warm-up count at the predictor order
  assign warmup_next = (count < ppz_pkg::COUNT_W'(ppz_pkg::ORDER)) ?
                       count + ppz_pkg::COUNT_W'(1) : ppz_pkg::COUNT_W'(ppz_pkg::ORDER);

  // Order 3: 3*(p1 - p2) + p3; order 2: 2*p1 - p2; all wrapping
  assign diff  = prev1 - prev2;
  assign slope = prev1 + diff;

  always_comb begin
    case (count)
      2'd0:    prediction = '0;
      2'd1:    prediction = prev1;
      2'd2:    prediction = slope;
      default: prediction = {diff[ppz_pkg::SAMPLE_W-2:0], 1'b0} + diff + prev3;
    endcase
  end

  // Shift history on each word that passes
  always_ff @(posedge clk) begin
    if (rst) begin
      warmup <= '0;
    end else if (advance) begin
      warmup <= warmup_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prev3 <= prev2;
      prev2 <= prev1;
      prev1 <= new_sample;
    end
  end

endmodule

FILE: rtl/ppz_core.sv
// Encode and decode datapath: stereo average, residual fold, code unfold.
// Uses ppz_pkg types and fold helpers; prediction comes from ppz_predictor.
`timescale 1ns / 1ps

module ppz_core (
  input  ppz_pkg::mode_t                   mode,
  input  ppz_pkg::in_word_t                in_word,
  input  logic [ppz_pkg::SAMPLE_W-1:0]     prediction,
  output ppz_pkg::out_word_t               out_word
);

  logic [ppz_pkg::SAMPLE_W:0]   pair_sum;
  logic [ppz_pkg::SAMPLE_W:0]   pair_adj;
  logic [ppz_pkg::SAMPLE_W-1:0] mono;
  logic [ppz_pkg::SAMPLE_W-1:0] residual;
  logic [ppz_pkg::SAMPLE_W-1:0] rebuilt;

  // Average to mono, rounding toward zero: bump negative odd sums before the shift
  assign pair_sum = {in_word.left_sample[ppz_pkg::SAMPLE_W-1], in_word.left_sample} +
                    {in_word.right_sample[ppz_pkg::SAMPLE_W-1], in_word.right_sample};
  assign pair_adj = pair_sum +
                    (ppz_pkg::SAMPLE_W+1)'(pair_sum[ppz_pkg::SAMPLE_W] & pair_sum[0]);
  assign mono     = pair_adj[ppz_pkg::SAMPLE_W:1];

  // Residual against the prediction, and rebuild from the unfolded code
  assign residual = mono - prediction;
  assign rebuilt  = ppz_pkg::unfold(in_word.folded_code) + prediction;

  // Select by mode; decode echoes the incoming code
  always_comb begin
    unique case (mode)
      ppz_pkg::MODE_ENCODE: begin
        out_word.sample          = mono;
        out_word.folded_residual = ppz_pkg::fold(residual);
      end
      default: begin
        out_word.sample          = rebuilt;
        out_word.folded_residual = in_word.folded_code;
      end
    endcase
  end

endmodule

FILE: rtl/polynomial_predictor_zigzag_residual.sv
// Top level of the polynomial predictor with zigzag residual folding.
// Instantiates ppz_predictor and ppz_core; types from ppz_pkg.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one word per sample:
//   a stereo pair and start flag (encode) or a folded code and start flag
//   (decode). Output channel out_valid / out_stall / out_data returns one word
//   per input word: the mono or rebuilt sample and the folded residual.
//   cfg_write / cfg_data write the mode bit (0 encode, 1 decode); write it only
//   while no word is in flight.
//   An accepted word sits in the input register and passes through the
//   datapath into the output register once that register is free, which
//   raises out_valid; the word leaves when out_stall is low.
//   Throughput is one word per cycle while the receiver does not stall; the
//   limit is the loop through history, prediction and sum in decode mode.
//   When the receiver stalls, the output word holds and the input register
//   fills; in_stall rises only once both registers are occupied.
//   Synchronous reset empties both registers, clears the warm-up count and
//   sets encode mode.
`timescale 1ns / 1ps

module polynomial_predictor_zigzag_residual (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ppz_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ppz_pkg::out_word_t  out_data
);

  ppz_pkg::mode_t               mode;
  logic                         hold_valid;
  ppz_pkg::in_word_t            hold_word;
  ppz_pkg::out_word_t           result;
  logic [ppz_pkg::SAMPLE_W-1:0] prediction;
  logic                         out_free;
  logic                         move;
  logic                         take;

  // Handshake: advance the held word whenever the output register can take it
  assign out_free = !out_valid || !out_stall;
  assign move     = hold_valid && out_free;
  assign in_stall = hold_valid && !out_free;
  assign take     = in_valid && !in_stall;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ppz_pkg::MODE_ENCODE;
    end else if (cfg_write) begin
      mode <= ppz_pkg::mode_t'(cfg_data);
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (take) begin
      hold_valid <= 1'b1;
    end else if (move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_word <= in_data;
    end
  end

  // History and prediction
  ppz_predictor u_predictor (
    .clk        (clk),
    .rst        (rst),
    .advance    (move),
    .start      (hold_word.start_of_stream),
    .new_sample (result.sample),
    .prediction (prediction)
  );

  // Encode / decode datapath
  ppz_core u_core (
    .mode       (mode),
    .in_word    (hold_word),
    .prediction (prediction),
    .out_word   (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // Stall only with a word parked in the input register
  a_stall_needs_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> hold_valid)
    else $error("in_stall raised with empty input register");

  // A word moved forward shows up at the output next cycle
  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    move |=> out_valid)
    else $error("moved word missing from output register");

  // A stalled output word is never overwritten by a move
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !move)
    else $error("output register overwritten while stalled");

  // Taking a new word while one is held requires the held word to leave
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (take && hold_valid) |-> move)
    else $error("held word dropped by new input");
`endif

endmodule
